@@ design/assert_macros.svh @@
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define RRA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while rst is high
`define RRA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/rra_pkg.sv @@
// types, widths and constants of the range running average block
package rra_pkg;

   localparam int NumSensorsDefault = 2;

   localparam int SensorW   = 1;
   localparam int DistW     = 16;
   localparam int SumW      = 24;
   localparam int CountW    = 8;
   localparam int AvgW      = 16;
   localparam int LimitW    = 16;
   localparam int WindowW   = 8;
   localparam int CsrIndexW = 1;
   localparam int CsrDataW  = 16;

   // divider operands: the sum may carry one extra bit, the count may reach 256
   localparam int DivW      = SumW + 1;
   localparam int DivisorW  = CountW + 1;
   localparam int DivStepW  = $clog2(DivW);

   localparam logic [LimitW-1:0]  RangeLimitReset = LimitW'(2000);
   localparam logic [WindowW-1:0] WindowReset     = WindowW'(8);

   typedef enum logic [CsrIndexW-1:0] {
      CSR_RANGE_LIMIT,
      CSR_WINDOW_SAMPLES
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_POST,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_TRIM,
      PH_AVG,
      PH_DECAY
   } div_phase_type;

   typedef struct packed {
      logic [SumW-1:0]   sum;
      logic [CountW-1:0] count;
      logic [AvgW-1:0]   avg;
   } entry_type;

endpackage

@@ design/rra_if.sv @@
// valid/ready channels for readings and results
interface rra_req_if;
   logic                       valid;
   logic                       ready;
   logic [rra_pkg::SensorW-1:0] sensor_index;
   logic [rra_pkg::DistW-1:0]   distance_mm;

   modport source (output valid, output sensor_index, output distance_mm, input ready);
   modport sink   (input valid, input sensor_index, input distance_mm, output ready);
endinterface

interface rra_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rra_pkg::SensorW-1:0] out_sensor;
   logic [rra_pkg::AvgW-1:0]    filtered_mm;
   logic [rra_pkg::DistW-1:0]   raw_mm;

   modport source (output valid, output out_sensor, output filtered_mm, output raw_mm,
                   input ready);
   modport sink   (input valid, input out_sensor, input filtered_mm, input raw_mm,
                   output ready);
endinterface

@@ design/range_running_average.sv @@
// Per-sensor running average of distance readings. One reading is taken at a time and
// gives one result beat. Each sensor's sum, count and average live in one small
// synchronous memory that is read, updated and written back per reading. The update
// runs through a bit-serial divider of 25 steps: an in-range reading that needs no
// trim or an out-of-range reading takes one division, an in-range reading that
// overflows the window takes two divisions. A result waiting in the output register
// does not block the next accept. Writing either configuration register clears every
// sensor's state at once (valid bits, no clearing pass). Readings tagged with a sensor
// at or above NUM_SENSORS leave the state alone and report an average of zero.
module range_running_average #(
   parameter int NUM_SENSORS = rra_pkg::NumSensorsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   rra_req_if.sink                       req_bus,
   rra_rsp_if.source                     rsp_bus,
   input  logic                          csr_we,
   input  logic [rra_pkg::CsrIndexW-1:0] csr_index,
   input  logic [rra_pkg::CsrDataW-1:0]  csr_wdata
);

   localparam int AddrW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

   // control state
   rra_pkg::state_type                state_ff, state_in;
   rra_pkg::div_phase_type            phase_ff, phase_in;
   logic [NUM_SENSORS-1:0]            valid_ff, valid_in;
   logic [rra_pkg::LimitW-1:0]        range_limit_ff, range_limit_in;
   logic [rra_pkg::WindowW-1:0]       window_ff, window_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [rra_pkg::DivStepW-1:0]      step_ff, step_in;

   // payload
   logic [rra_pkg::SensorW-1:0]       sel_ff, sel_in;
   logic [rra_pkg::DistW-1:0]         dist_ff, dist_in;
   logic [rra_pkg::DivW-1:0]          sum_ff, sum_in;
   logic [rra_pkg::DivisorW-1:0]      cnt_ff, cnt_in;
   logic [rra_pkg::AvgW-1:0]          avg_ff, avg_in;
   logic [rra_pkg::DivW-1:0]          quo_ff, quo_in;
   logic [rra_pkg::DivisorW-1:0]      rem_ff, rem_in;
   logic [rra_pkg::DivisorW-1:0]      divisor_ff, divisor_in;
   logic [rra_pkg::SensorW-1:0]       rsp_sensor_ff, rsp_sensor_in;
   logic [rra_pkg::AvgW-1:0]          rsp_filtered_ff, rsp_filtered_in;
   logic [rra_pkg::DistW-1:0]         rsp_raw_ff, rsp_raw_in;

   // sensor store
   rra_pkg::entry_type                mem [NUM_SENSORS];
   rra_pkg::entry_type                rd_data_ff;
   rra_pkg::entry_type                mem_wdata;
   logic                              mem_we;
   logic [AddrW-1:0]                  rd_addr;
   logic [AddrW-1:0]                  wr_addr;

   // combinational helpers
   logic                              sel_ok;
   rra_pkg::entry_type                entry;
   logic [rra_pkg::DivW-1:0]          sum_add;
   logic [rra_pkg::DivisorW-1:0]      cnt_add;
   logic [rra_pkg::DivW-1:0]          sum_sub;
   logic [rra_pkg::DivisorW-1:0]      cnt_dec;
   logic [rra_pkg::DivisorW:0]        trial;
   logic                              trial_ge;
   logic                              div_start;
   logic [rra_pkg::DivW-1:0]          div_dividend;
   logic [rra_pkg::DivisorW-1:0]      div_divisor;

   assign rd_addr = AddrW'(req_bus.sensor_index);
   assign wr_addr = AddrW'(sel_ff);
   assign sel_ok  = (32'(sel_ff) < NUM_SENSORS);

   assign req_bus.ready       = (state_ff == rra_pkg::ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_sensor  = rsp_sensor_ff;
   assign rsp_bus.filtered_mm = rsp_filtered_ff;
   assign rsp_bus.raw_mm      = rsp_raw_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      entry    = valid_ff[wr_addr] ? rd_data_ff : '0;
      sum_add  = rra_pkg::DivW'(entry.sum) + rra_pkg::DivW'(dist_ff);
      cnt_add  = rra_pkg::DivisorW'(entry.count) + rra_pkg::DivisorW'(1);
      sum_sub  = sum_ff - quo_ff;
      cnt_dec  = (cnt_ff == '0) ? '0 : cnt_ff - rra_pkg::DivisorW'(1);
      trial    = {rem_ff, quo_ff[rra_pkg::DivW-1]};
      trial_ge = (trial >= {1'b0, divisor_ff});
   end

   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      valid_in        = valid_ff;
      range_limit_in  = range_limit_ff;
      window_in       = window_ff;
      rsp_valid_in    = rsp_valid_ff;
      step_in         = step_ff;
      sel_in          = sel_ff;
      dist_in         = dist_ff;
      sum_in          = sum_ff;
      cnt_in          = cnt_ff;
      avg_in          = avg_ff;
      quo_in          = quo_ff;
      rem_in          = rem_ff;
      divisor_in      = divisor_ff;
      rsp_sensor_in   = rsp_sensor_ff;
      rsp_filtered_in = rsp_filtered_ff;
      rsp_raw_in      = rsp_raw_ff;
      mem_we          = 1'b0;
      mem_wdata       = '0;
      div_start       = 1'b0;
      div_dividend    = '0;
      div_divisor     = '0;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         rra_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               sel_in   = req_bus.sensor_index;
               dist_in  = req_bus.distance_mm;
               state_in = rra_pkg::ST_READ;
            end
         end
         rra_pkg::ST_READ: begin
            if (!sel_ok) begin
               avg_in   = '0;
               state_in = rra_pkg::ST_DONE;
            end else begin
               avg_in = entry.avg;
               if (dist_ff < range_limit_ff) begin
                  sum_in       = sum_add;
                  cnt_in       = cnt_add;
                  phase_in     = (cnt_add > rra_pkg::DivisorW'(window_ff)) ?
                                 rra_pkg::PH_TRIM : rra_pkg::PH_AVG;
                  div_start    = 1'b1;
                  div_dividend = sum_add;
                  div_divisor  = cnt_add;
               end else begin
                  sum_in       = rra_pkg::DivW'(entry.sum);
                  cnt_in       = rra_pkg::DivisorW'(entry.count);
                  phase_in     = rra_pkg::PH_DECAY;
                  div_start    = 1'b1;
                  div_dividend = rra_pkg::DivW'(entry.sum);
                  div_divisor  = (entry.count == '0) ? rra_pkg::DivisorW'(1) :
                                 rra_pkg::DivisorW'(entry.count);
               end
            end
         end
         rra_pkg::ST_DIV: begin
            // one quotient bit per cycle
            quo_in = {quo_ff[rra_pkg::DivW-2:0], trial_ge};
            rem_in = trial_ge ? rra_pkg::DivisorW'(trial - {1'b0, divisor_ff}) :
                                trial[rra_pkg::DivisorW-1:0];
            step_in = step_ff + rra_pkg::DivStepW'(1);
            if (step_ff == rra_pkg::DivStepW'(rra_pkg::DivW - 1)) begin
               state_in = rra_pkg::ST_POST;
            end
         end
         rra_pkg::ST_POST: begin
            case (phase_ff)
               rra_pkg::PH_TRIM: begin
                  sum_in       = sum_sub;
                  cnt_in       = cnt_dec;
                  phase_in     = rra_pkg::PH_AVG;
                  div_start    = 1'b1;
                  div_dividend = sum_sub;
                  div_divisor  = (cnt_dec == '0) ? rra_pkg::DivisorW'(1) : cnt_dec;
               end
               rra_pkg::PH_AVG: begin
                  avg_in   = quo_ff[rra_pkg::AvgW-1:0];
                  state_in = rra_pkg::ST_DONE;
               end
               default: begin
                  sum_in   = sum_sub;
                  cnt_in   = cnt_dec;
                  state_in = rra_pkg::ST_DONE;
               end
            endcase
         end
         rra_pkg::ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_bus.ready) begin
               mem_we          = sel_ok;
               mem_wdata.sum   = sum_ff[rra_pkg::SumW-1:0];
               mem_wdata.count = cnt_ff[rra_pkg::CountW-1:0];
               mem_wdata.avg   = avg_ff;
               if (sel_ok) begin
                  valid_in[wr_addr] = 1'b1;
               end
               rsp_valid_in    = 1'b1;
               rsp_sensor_in   = sel_ff;
               rsp_filtered_in = avg_ff;
               rsp_raw_in      = dist_ff;
               state_in        = rra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rra_pkg::ST_IDLE;
         end
      endcase

      if (div_start) begin
         quo_in     = div_dividend;
         rem_in     = '0;
         divisor_in = div_divisor;
         step_in    = '0;
         state_in   = rra_pkg::ST_DIV;
      end

      if (csr_we) begin
         unique case (rra_pkg::csr_index_type'(csr_index))
            rra_pkg::CSR_RANGE_LIMIT: begin
               range_limit_in = csr_wdata[rra_pkg::LimitW-1:0];
            end
            rra_pkg::CSR_WINDOW_SAMPLES: begin
               window_in = csr_wdata[rra_pkg::WindowW-1:0];
            end
            default: begin
               window_in = window_ff;
            end
         endcase
         valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rra_pkg::ST_IDLE;
         phase_ff       <= rra_pkg::PH_AVG;
         valid_ff       <= '0;
         range_limit_ff <= rra_pkg::RangeLimitReset;
         window_ff      <= rra_pkg::WindowReset;
         rsp_valid_ff   <= 1'b0;
         step_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         valid_ff       <= valid_in;
         range_limit_ff <= range_limit_in;
         window_ff      <= window_in;
         rsp_valid_ff   <= rsp_valid_in;
         step_ff        <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff          <= sel_in;
      dist_ff         <= dist_in;
      sum_ff          <= sum_in;
      cnt_ff          <= cnt_in;
      avg_ff          <= avg_in;
      quo_ff          <= quo_in;
      rem_ff          <= rem_in;
      divisor_ff      <= divisor_in;
      rsp_sensor_ff   <= rsp_sensor_in;
      rsp_filtered_ff <= rsp_filtered_in;
      rsp_raw_ff      <= rsp_raw_in;
   end

endmodule

@@ design/rra_checker.sv @@
// port-level checks of the range running average block, bound to its top level
`include "assert_macros.svh"

module rra_checker #(
   parameter int NUM_SENSORS = rra_pkg::NumSensorsDefault
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [rra_pkg::SensorW-1:0] rsp_out_sensor,
   input logic [rra_pkg::AvgW-1:0]    rsp_filtered_mm,
   input logic [rra_pkg::DistW-1:0]   rsp_raw_mm
);

   localparam int BeatW = rra_pkg::SensorW + rra_pkg::AvgW + rra_pkg::DistW;

   logic             rsp_stall;
   logic             unknown_sensor;
   logic [BeatW-1:0] rsp_beat;

   assign rsp_stall      = rsp_valid && !rsp_ready;
   assign unknown_sensor = (32'(rsp_out_sensor) >= NUM_SENSORS);
   assign rsp_beat       = {rsp_out_sensor, rsp_filtered_mm, rsp_raw_mm};

   // a stalled result beat holds
   `RRA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_beat))

   // one reading at a time: no accept in the cycle after an accept
   `RRA_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

   // an unknown sensor reports a zero average
   `RRA_ASSERT_IMPLY(a_unknown_sensor, clock, reset, rsp_valid && unknown_sensor, rsp_filtered_mm == '0)

   // reset empties the output register
   `RRA_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

endmodule

bind range_running_average rra_checker #(.NUM_SENSORS(NUM_SENSORS)) u_rra_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_out_sensor  (rsp_bus.out_sensor),
   .rsp_filtered_mm (rsp_bus.filtered_mm),
   .rsp_raw_mm      (rsp_bus.raw_mm)
);

@@ tb/range_running_average_tb.sv @@
// self-checking testbench for range_running_average: directed table, then random config phases
module range_running_average_tb;

   localparam int SENSORS       = 2;
   localparam int SETTLE_CYCLES = 64;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int MAX_REPORTS   = 10;

   typedef enum {STEP_READING, STEP_WRITE} step_kind_type;

   typedef enum {RX_OPEN, RX_SPARSE, RX_COMB, RX_COIN} rx_mode_type;

   typedef struct {
      step_kind_type                  kind;
      rra_pkg::csr_index_type         reg_sel;
      logic [rra_pkg::CsrDataW-1:0]   wdata;
      logic [rra_pkg::SensorW-1:0]    sensor;
      logic [rra_pkg::DistW-1:0]      reading_mm;
      bit                             typed;
      logic [rra_pkg::AvgW-1:0]       filt;
   } directed_step_type;

   typedef struct {
      logic [rra_pkg::SensorW-1:0] sensor;
      logic [rra_pkg::AvgW-1:0]    filt;
      logic [rra_pkg::DistW-1:0]   raw;
   } reading_result_type;

   logic clock;
   logic reset;
   logic                          csr_we;
   logic [rra_pkg::CsrIndexW-1:0] csr_index;
   logic [rra_pkg::CsrDataW-1:0]  csr_wdata;

   rra_req_if req_ch ();
   rra_rsp_if rsp_ch ();

   range_running_average #(
      .NUM_SENSORS(SENSORS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the block's registers and per-sensor stores
   logic [rra_pkg::LimitW-1:0]  limit_reg;
   logic [rra_pkg::WindowW-1:0] window_reg;
   logic [rra_pkg::SumW-1:0]    sum_mem   [SENSORS];
   logic [rra_pkg::CountW-1:0]  count_mem [SENSORS];
   logic [rra_pkg::AvgW-1:0]    avg_mem   [SENSORS];

   reading_result_type pending_results [$];
   int fail_count;
   int burst_left;

   // the extremes of the fields, the count saturating at zero, window one, zero and full,
   // range limit zero and full
   directed_step_type directed_steps [24] = '{
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b0, 16'd0,     1'b1, 16'd0},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b0, 16'd1999,  1'b1, 16'd999},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b0, 16'd2000,  1'b1, 16'd999},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b0, 16'd65535, 1'b1, 16'd999},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b0, 16'd65535, 1'b1, 16'd999},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b1, 16'd1234,  1'b1, 16'd1234},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b1, 16'd0,     1'b1, 16'd617},
      '{STEP_WRITE,   rra_pkg::CSR_WINDOW_SAMPLES, 16'h0001, 1'b0, 16'd0,     1'b0, 16'd0},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b0, 16'd500,   1'b1, 16'd500},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b0, 16'd1000,  1'b1, 16'd750},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b0, 16'd1998,  1'b1, 16'd1374},
      '{STEP_WRITE,   rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b0, 16'd0,     1'b0, 16'd0},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b1, 16'd0,     1'b1, 16'd0},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b0, 16'd0,     1'b1, 16'd0},
      '{STEP_WRITE,   rra_pkg::CSR_WINDOW_SAMPLES, 16'h0000, 1'b0, 16'd0,     1'b0, 16'd0},
      '{STEP_WRITE,   rra_pkg::CSR_RANGE_LIMIT,    16'hFFFF, 1'b0, 16'd0,     1'b0, 16'd0},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b0, 16'd65534, 1'b1, 16'd0},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b1, 16'd1,     1'b1, 16'd0},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b0, 16'd65535, 1'b1, 16'd0},
      '{STEP_WRITE,   rra_pkg::CSR_WINDOW_SAMPLES, 16'h5AFF, 1'b0, 16'd0,     1'b0, 16'd0},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b1, 16'd65534, 1'b1, 16'd65534},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b1, 16'd65534, 1'b1, 16'd65534},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b1, 16'd0,     1'b0, 16'd0},
      '{STEP_READING, rra_pkg::CSR_RANGE_LIMIT,    16'h0000, 1'b0, 16'd65535, 1'b1, 16'd0}
   };

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic void clear_averages();
      for (int k = 0; k < SENSORS; k++) begin
         sum_mem[k]   = '0;
         count_mem[k] = '0;
         avg_mem[k]   = '0;
      end
   endfunction

   // update one sensor's running average and return the filtered value it reports
   function automatic logic [rra_pkg::AvgW-1:0] predict_average(
         input logic [rra_pkg::SensorW-1:0] sel,
         input logic [rra_pkg::DistW-1:0]   reading_mm);
      int unsigned acc;
      int unsigned n;
      logic [rra_pkg::AvgW-1:0] filt;
      filt = '0;
      if (int'(sel) < SENSORS) begin
         acc = sum_mem[sel];
         n   = count_mem[sel];
         if (reading_mm < limit_reg) begin
            acc += reading_mm;
            n   += 1;
            if (n > window_reg) begin
               acc -= acc / n;
               n   -= 1;
            end
            avg_mem[sel] = rra_pkg::AvgW'(acc / ((n > 0) ? n : 1));
         end else begin
            acc -= acc / ((n > 0) ? n : 1);
            if (n > 0) n -= 1;
         end
         sum_mem[sel]   = rra_pkg::SumW'(acc);
         count_mem[sel] = rra_pkg::CountW'(n);
         filt = avg_mem[sel];
      end
      return filt;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("mismatch %s: expected %0d, got %0d", what, want, got);
   endtask

   // burst pacing: a random gap opens once the current burst is used up
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 70);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
   endtask

   task automatic send_reading(input logic [rra_pkg::SensorW-1:0] sel,
                               input logic [rra_pkg::DistW-1:0]   reading_mm,
                               input bit                          typed,
                               input logic [rra_pkg::AvgW-1:0]    typed_filt);
      reading_result_type want;
      logic [rra_pkg::AvgW-1:0] filt;
      pace_sender();
      req_ch.valid        <= 1'b1;
      req_ch.sensor_index <= sel;
      req_ch.distance_mm  <= reading_mm;
      do @(posedge clock); while (!req_ch.ready);
      filt = predict_average(sel, reading_mm);
      want.sensor = sel;
      want.filt   = typed ? typed_filt : filt;
      want.raw    = reading_mm;
      pending_results.push_back(want);
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic write_register(input rra_pkg::csr_index_type idx,
                                 input logic [rra_pkg::CsrDataW-1:0] data);
      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         rra_pkg::CSR_RANGE_LIMIT:    limit_reg  = data[rra_pkg::LimitW-1:0];
         rra_pkg::CSR_WINDOW_SAMPLES: window_reg = data[rra_pkg::WindowW-1:0];
         default: ;
      endcase
      clear_averages();
   endtask

   // receiver: a random stall style is held for a random span, then redrawn; open stretches included
   initial begin
      rx_mode_type mode;
      int          hold;
      int          tick;
      mode = RX_OPEN;
      hold = 0;
      tick = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold == 0) begin
            mode = rx_mode_type'($urandom_range(0, 3));
            hold = $urandom_range(50, 400);
         end
         hold--;
         tick++;
         case (mode)
            RX_OPEN:   rsp_ch.ready <= 1'b1;
            RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 5) == 0);
            RX_COMB:   rsp_ch.ready <= ((tick % 11) < 4);
            default:   rsp_ch.ready <= $urandom_range(0, 1);
         endcase
      end
   end

   always @(posedge clock) begin
      reading_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            note_mismatch("result beat with nothing pending, raw_mm", 0, rsp_ch.raw_mm);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.out_sensor !== want.sensor)
               note_mismatch("out_sensor", want.sensor, rsp_ch.out_sensor);
            if (rsp_ch.filtered_mm !== want.filt)
               note_mismatch("filtered_mm", want.filt, rsp_ch.filtered_mm);
            if (rsp_ch.raw_mm !== want.raw)
               note_mismatch("raw_mm", want.raw, rsp_ch.raw_mm);
         end
      end
   end

   initial begin
      #6_400_000;
      $display("range_running_average verification failed");
      $finish;
   end

   initial begin
      int unsigned                 lim;
      int unsigned                 win;
      int                          count;
      int                          pick;
      bit                          deep;
      logic [rra_pkg::SensorW-1:0] sel;
      logic [rra_pkg::DistW-1:0]   reading_mm;
      fail_count = 0;
      burst_left = 0;
      limit_reg  = rra_pkg::RangeLimitReset;
      window_reg = rra_pkg::WindowReset;
      clear_averages();
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= rra_pkg::CSR_RANGE_LIMIT;
      csr_wdata           <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.sensor_index <= '0;
      req_ch.distance_mm  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_WRITE)
            write_register(directed_steps[i].reg_sel, directed_steps[i].wdata);
         else
            send_reading(directed_steps[i].sensor, directed_steps[i].reading_mm,
                         directed_steps[i].typed, directed_steps[i].filt);
      end

      // first phase fills a full window on sensor 0 with large readings to stress the sum
      for (int phase = 0; phase < 6; phase++) begin
         deep = (phase == 0);
         if (deep) begin
            lim = 65535;
            win = 255;
         end else begin
            pick = $urandom_range(0, 5);
            case (pick)
               0:       lim = 1;
               1:       lim = 2000;
               2:       lim = 65535;
               3:       lim = (phase == 3) ? 0 : $urandom_range(1, 65535);
               default: lim = $urandom_range(1, 65535);
            endcase
            pick = $urandom_range(0, 5);
            case (pick)
               0:       win = 0;
               1:       win = 1;
               2:       win = 8;
               3:       win = 255;
               default: win = $urandom_range(1, 255);
            endcase
         end
         write_register(rra_pkg::CSR_RANGE_LIMIT, rra_pkg::CsrDataW'(lim));
         write_register(rra_pkg::CSR_WINDOW_SAMPLES,
                        {8'($urandom_range(0, 255)), rra_pkg::WindowW'(win)});
         count = deep ? 320 : 116;
         repeat (count) begin
            sel  = deep ? rra_pkg::SensorW'($urandom_range(0, 9) == 0)
                        : rra_pkg::SensorW'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 4)
               reading_mm = '0;
            else if (pick < 8)
               reading_mm = '1;
            else if (lim > 0 && pick < (deep ? 96 : 78))
               reading_mm = (deep && pick < 60) ?
                            rra_pkg::DistW'($urandom_range(60000, lim - 1)) :
                            rra_pkg::DistW'($urandom_range(0, lim - 1));
            else
               reading_mm = rra_pkg::DistW'($urandom_range(lim, 65535));
            send_reading(sel, reading_mm, 1'b0, '0);
         end
      end

      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("range_running_average verification clean");
      end else begin
         $display("range_running_average verification failed");
      end
      $finish;
   end

endmodule

@@ range_running_average.f @@
+incdir+design
design/rra_pkg.sv
design/rra_if.sv
design/range_running_average.sv
design/rra_checker.sv
tb/range_running_average_tb.sv
